/* sv/rfpwt_pkg.sv */
// ----------------------------------------------------------------------------
// rfpwt_pkg
// Types, register indexes, reset values and helpers for the pulse width
// transmitter.
// ----------------------------------------------------------------------------
package rfpwt_pkg;

	localparam int unsigned TIME_W    = 16;
	localparam int unsigned COUNT_W   = 8;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned HDR_W     = 32;
	localparam int unsigned CMD_W     = 8;
	localparam int unsigned MAX_FRAME = 64;

	localparam logic [TIME_W-1:0]  SHORT_RST     = 16'd320;
	localparam logic [TIME_W-1:0]  LONG_RST      = 16'd620;
	localparam logic [TIME_W-1:0]  SYNC_HI_RST   = 16'd4500;
	localparam logic [TIME_W-1:0]  SYNC_LO_RST   = 16'd1400;
	localparam logic [TIME_W-1:0]  GAP_RST       = 16'd7400;
	localparam logic [COUNT_W-1:0] REPEAT_RST    = 8'd5;
	localparam logic [CMD_W-1:0]   NIBBLE_MASK   = 8'h0f;

	localparam logic OP_TICK  = 1'b0;
	localparam logic OP_START = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SHORT   = 3'd0,
		REG_LONG    = 3'd1,
		REG_SYNC_HI = 3'd2,
		REG_SYNC_LO = 3'd3,
		REG_GAP     = 3'd4,
		REG_REPEAT  = 3'd5
	} reg_idx_t;

	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_SYNC_HI = 3'd1,
		PH_SYNC_LO = 3'd2,
		PH_BIT_HI  = 3'd3,
		PH_BIT_LO  = 3'd4,
		PH_GAP     = 3'd5
	} phase_t;

	typedef struct packed {
		logic [TIME_W-1:0]  short_time;
		logic [TIME_W-1:0]  long_time;
		logic [TIME_W-1:0]  sync_high_time;
		logic [TIME_W-1:0]  sync_low_time;
		logic [TIME_W-1:0]  gap_time;
		logic [COUNT_W-1:0] repeat_count;
	} cfg_t;

	typedef struct packed {
		logic             operation;
		logic [HDR_W-1:0] header_word;
		logic [CMD_W-1:0] command_code;
		logic             invert_pass;
	} item_t;

	typedef struct packed {
		logic line_level;
		logic busy_res;
		logic finished;
	} res_t;

	// a zero duration lasts one tick
	function automatic logic [TIME_W-1:0] dur(input logic [TIME_W-1:0] v);
		dur = (v == '0) ? TIME_W'(1) : v;
	endfunction

endpackage

/* sv/rfpwt_cfg.sv */
// ----------------------------------------------------------------------------
// rfpwt_cfg
// Timing and repeat registers, written through the configuration channel.
// ----------------------------------------------------------------------------
module rfpwt_cfg
	import rfpwt_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [TIME_W-1:0]    wr_data,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.short_time     <= SHORT_RST;
			cfg_q.long_time      <= LONG_RST;
			cfg_q.sync_high_time <= SYNC_HI_RST;
			cfg_q.sync_low_time  <= SYNC_LO_RST;
			cfg_q.gap_time       <= GAP_RST;
			cfg_q.repeat_count   <= REPEAT_RST;
		end else if (wr_en) begin
			// unknown indexes drop silently
			case (wr_index)
				REG_SHORT:   cfg_q.short_time     <= wr_data;
				REG_LONG:    cfg_q.long_time      <= wr_data;
				REG_SYNC_HI: cfg_q.sync_high_time <= wr_data;
				REG_SYNC_LO: cfg_q.sync_low_time  <= wr_data;
				REG_GAP:     cfg_q.gap_time       <= wr_data;
				REG_REPEAT:  cfg_q.repeat_count   <= wr_data[COUNT_W-1:0];
				default:     ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* sv/rfpwt_seq.sv */
// ----------------------------------------------------------------------------
// rfpwt_seq
// Segment sequencer: sync, frame bits, gap, repeats and the inverted pass.
// Computes the result of one item and updates the state when it steps.
// ----------------------------------------------------------------------------
module rfpwt_seq
	import rfpwt_pkg::*;
#(
	parameter int unsigned FRAME_BITS = 40
)(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  step,
	input  item_t item,
	input  cfg_t  cfg,
	output res_t  res,
	output logic  busy
);

	localparam int unsigned POS_W = $clog2(FRAME_BITS);
	localparam logic [POS_W-1:0] POS_TOP = POS_W'(FRAME_BITS - 1);

	phase_t                 phase_q, phase_nx;
	logic [POS_W-1:0]       pos_q, pos_nx;
	logic [COUNT_W-1:0]     rep_q, rep_nx;
	logic [TIME_W-1:0]      time_q, time_nx, time_dec;
	logic [FRAME_BITS-1:0]  frame_q, frame_nx;
	logic                   pend_q, pend_nx;
	logic                   line_q, line_nx;
	logic                   fin;
	logic [MAX_FRAME-1:0]   load_word;
	logic                   bit_cur, bit_top, bit_dn;

	assign time_dec  = time_q - TIME_W'(1);
	assign load_word = {{(MAX_FRAME - HDR_W - CMD_W){1'b0}}, item.header_word, item.command_code};
	assign bit_cur   = frame_q[pos_q];
	assign bit_top   = frame_q[POS_TOP];
	assign bit_dn    = frame_q[pos_q - POS_W'(1)];

	// next state
	always_comb begin
		phase_nx = phase_q;
		pos_nx   = pos_q;
		rep_nx   = rep_q;
		time_nx  = time_q;
		frame_nx = frame_q;
		pend_nx  = pend_q;
		line_nx  = line_q;
		fin      = 1'b0;
		if (item.operation == OP_START) begin
			if (phase_q == PH_IDLE && cfg.repeat_count != '0) begin
				frame_nx = load_word[FRAME_BITS-1:0];
				pend_nx  = item.invert_pass;
				rep_nx   = cfg.repeat_count;
				pos_nx   = '0;
				phase_nx = PH_SYNC_HI;
				time_nx  = dur(cfg.sync_high_time);
				line_nx  = 1'b1;
			end
		end else if (phase_q != PH_IDLE) begin
			time_nx = time_dec;
			if (time_dec == '0) begin
				unique case (phase_q)
					PH_SYNC_HI: begin
						phase_nx = PH_SYNC_LO;
						time_nx  = dur(cfg.sync_low_time);
						line_nx  = 1'b0;
					end
					PH_SYNC_LO: begin
						pos_nx   = POS_TOP;
						phase_nx = PH_BIT_HI;
						time_nx  = dur(bit_top ? cfg.long_time : cfg.short_time);
						line_nx  = 1'b1;
					end
					PH_BIT_HI: begin
						phase_nx = PH_BIT_LO;
						time_nx  = dur(bit_cur ? cfg.short_time : cfg.long_time);
						line_nx  = 1'b0;
					end
					PH_BIT_LO: begin
						if (pos_q != '0) begin
							pos_nx   = pos_q - POS_W'(1);
							phase_nx = PH_BIT_HI;
							time_nx  = dur(bit_dn ? cfg.long_time : cfg.short_time);
							line_nx  = 1'b1;
						end else begin
							phase_nx = PH_GAP;
							time_nx  = dur(cfg.gap_time);
							line_nx  = 1'b0;
						end
					end
					default: begin
						// end of gap: next repeat, second pass or done
						line_nx = 1'b0;
						rep_nx  = rep_q - COUNT_W'(1);
						if (rep_nx != '0) begin
							phase_nx = PH_SYNC_HI;
							time_nx  = dur(cfg.sync_high_time);
							line_nx  = 1'b1;
						end else if (pend_q && cfg.repeat_count != '0) begin
							pend_nx  = 1'b0;
							frame_nx = frame_q ^ FRAME_BITS'(NIBBLE_MASK);
							rep_nx   = cfg.repeat_count;
							phase_nx = PH_SYNC_HI;
							time_nx  = dur(cfg.sync_high_time);
							line_nx  = 1'b1;
						end else begin
							pend_nx  = 1'b0;
							phase_nx = PH_IDLE;
							time_nx  = '0;
							pos_nx   = '0;
							fin      = 1'b1;
						end
					end
				endcase
			end
		end
	end

	// outputs
	always_comb begin
		res.line_level = line_nx;
		res.busy_res   = (phase_nx != PH_IDLE);
		res.finished   = fin;
		busy           = (phase_q != PH_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			pos_q   <= '0;
			rep_q   <= '0;
			time_q  <= '0;
			pend_q  <= 1'b0;
			line_q  <= 1'b0;
		end else if (step) begin
			phase_q <= phase_nx;
			pos_q   <= pos_nx;
			rep_q   <= rep_nx;
			time_q  <= time_nx;
			pend_q  <= pend_nx;
			line_q  <= line_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			frame_q <= frame_nx;
		end
	end

endmodule

/* sv/rf_remote_pulse_width_transmitter_top.sv */
// Path: an item is held in the input register and its result in the output register.
// Throughput: one item per cycle while results are taken; a result held in
//   the output register stalls the input once the input register also
//   holds an item.
// Reset: asynchronous; the valid flags clear, the sequencer idles and the
//   timing registers return to their default values.
// ----------------------------------------------------------------------------
// rf_remote_pulse_width_transmitter_top
// On-off keyed pulse width encoder for a shutter remote: sync pulse, frame
// bits MSB first, gap, with repeats and an optional inverted-nibble pass.
// ----------------------------------------------------------------------------
module rf_remote_pulse_width_transmitter_top
	import rfpwt_pkg::*;
#(
	parameter int unsigned FRAME_BITS = 40
)(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 operation,
	input  logic [HDR_W-1:0]     header_word,
	input  logic [CMD_W-1:0]     command_code,
	input  logic                 invert_pass,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 line_level,
	output logic                 busy_res,
	output logic                 finished,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [TIME_W-1:0]    cfg_data
);

	cfg_t  cfg;
	item_t item_s1;
	logic  valid_s1;
	res_t  res_nx;
	res_t  res_s2;
	logic  valid_s2;
	logic  advance;
	logic  seq_busy;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready  = !valid_s1 || advance;

	rfpwt_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	rfpwt_seq #(
		.FRAME_BITS (FRAME_BITS)
	) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res_nx),
		.busy   (seq_busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.operation    <= operation;
			item_s1.header_word  <= header_word;
			item_s1.command_code <= command_code;
			item_s1.invert_pass  <= invert_pass;
		end
		if (advance) begin
			res_s2 <= res_nx;
		end
	end

	assign out_valid  = valid_s2;
	assign line_level = res_s2.line_level;
	assign busy_res   = res_s2.busy_res;
	assign finished   = res_s2.finished;

	a_fin_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> !(res_s2.finished && res_s2.busy_res))
		else $error("finished reported while still busy");

	a_fin_line_low: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.finished |-> !res_s2.line_level)
		else $error("line high at end of transmission");

	a_busy_matches: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (res_s2.busy_res == seq_busy))
		else $error("held busy result disagrees with sequencer state");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 |-> in_ready)
		else $error("input stalled with an empty output register");

endmodule

/* tb/sv/rfpwt_line_checker.sv */
// ----------------------------------------------------------------------------
// rfpwt_line_checker
// Watches the item, result and register channels of the pulse width
// transmitter, predicts line level, busy and finished for every accepted
// item and compares them with the results that the block returns.
// ----------------------------------------------------------------------------
module rfpwt_line_checker
	import rfpwt_pkg::*;
#(
	parameter int unsigned FRAME_BITS = 40
)(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  logic                 operation,
	input  logic [HDR_W-1:0]     header_word,
	input  logic [CMD_W-1:0]     command_code,
	input  logic                 invert_pass,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  logic                 line_level,
	input  logic                 busy_res,
	input  logic                 finished,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [TIME_W-1:0]    cfg_data,
	output int unsigned          failures,
	output int unsigned          outstanding
);

	localparam logic [MAX_FRAME-1:0] FRAME_MASK =
		(FRAME_BITS >= MAX_FRAME) ? '1 : ((MAX_FRAME'(1) << FRAME_BITS) - MAX_FRAME'(1));

	// encoder copy: timing registers and sequencer state
	cfg_t                 timing;
	phase_t               seg;
	logic [5:0]           bit_pos;
	logic [COUNT_W-1:0]   reps_left;
	logic [TIME_W-1:0]    ticks_left;
	logic [MAX_FRAME-1:0] frame;
	logic                 pass2_armed;
	logic                 tx_level;

	res_t        line_q[$];
	int unsigned errs;

	function automatic logic [TIME_W-1:0] at_least_one(input logic [TIME_W-1:0] v);
		return (v == '0) ? TIME_W'(1) : v;
	endfunction

	function automatic void start_sync();
		seg        = PH_SYNC_HI;
		ticks_left = at_least_one(timing.sync_high_time);
		tx_level   = 1'b1;
	endfunction

	function automatic void start_bit();
		seg        = PH_BIT_HI;
		ticks_left = at_least_one(frame[bit_pos] ? timing.long_time : timing.short_time);
		tx_level   = 1'b1;
	endfunction

	function automatic void write_timing(input logic [CFG_IDX_W-1:0] idx,
			input logic [TIME_W-1:0] data);
		case (reg_idx_t'(idx))
			REG_SHORT:   timing.short_time     = data;
			REG_LONG:    timing.long_time      = data;
			REG_SYNC_HI: timing.sync_high_time = data;
			REG_SYNC_LO: timing.sync_low_time  = data;
			REG_GAP:     timing.gap_time       = data;
			REG_REPEAT:  timing.repeat_count   = data[COUNT_W-1:0];
			default: ;
		endcase
	endfunction

	function automatic res_t advance_encoder(input logic op, input logic [HDR_W-1:0] hdr,
			input logic [CMD_W-1:0] cmd, input logic inv);
		logic done;
		done = 1'b0;
		if (op == OP_START) begin
			// drop a start while busy or with no repeats
			if (seg == PH_IDLE && timing.repeat_count != '0) begin
				frame       = MAX_FRAME'({hdr, cmd}) & FRAME_MASK;
				pass2_armed = inv;
				reps_left   = timing.repeat_count;
				bit_pos     = '0;
				start_sync();
			end
		end else if (seg != PH_IDLE) begin
			ticks_left = ticks_left - 1'b1;
			if (ticks_left == '0) begin
				case (seg)
					PH_SYNC_HI: begin
						seg        = PH_SYNC_LO;
						ticks_left = at_least_one(timing.sync_low_time);
						tx_level   = 1'b0;
					end
					PH_SYNC_LO: begin
						bit_pos = 6'(FRAME_BITS - 1);
						start_bit();
					end
					PH_BIT_HI: begin
						seg        = PH_BIT_LO;
						ticks_left = at_least_one(frame[bit_pos] ? timing.short_time
							: timing.long_time);
						tx_level   = 1'b0;
					end
					PH_BIT_LO: begin
						if (bit_pos != '0) begin
							bit_pos = bit_pos - 1'b1;
							start_bit();
						end else begin
							seg        = PH_GAP;
							ticks_left = at_least_one(timing.gap_time);
							tx_level   = 1'b0;
						end
					end
					PH_GAP: begin
						tx_level  = 1'b0;
						reps_left = reps_left - 1'b1;
						if (reps_left != '0) begin
							start_sync();
						end else if (pass2_armed && timing.repeat_count != '0) begin
							// second pass: flip the low command nibble
							pass2_armed = 1'b0;
							frame       = frame ^ MAX_FRAME'(NIBBLE_MASK);
							reps_left   = timing.repeat_count;
							start_sync();
						end else begin
							pass2_armed = 1'b0;
							seg         = PH_IDLE;
							ticks_left  = '0;
							bit_pos     = '0;
							done        = 1'b1;
						end
					end
					default: ;
				endcase
			end
		end
		return {tx_level, seg != PH_IDLE, done};
	endfunction

	function automatic void check_bit(input string field, input logic want, input logic got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0b, actual %0b", $time, field, want, got);
			errs++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		res_t got;
		if (!arst_n) begin
			timing.short_time     = SHORT_RST;
			timing.long_time      = LONG_RST;
			timing.sync_high_time = SYNC_HI_RST;
			timing.sync_low_time  = SYNC_LO_RST;
			timing.gap_time       = GAP_RST;
			timing.repeat_count   = REPEAT_RST;
			seg         = PH_IDLE;
			bit_pos     = '0;
			reps_left   = '0;
			ticks_left  = '0;
			frame       = '0;
			pass2_armed = 1'b0;
			tx_level    = 1'b0;
			line_q.delete();
			errs        = 0;
			failures    <= 0;
			outstanding <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				write_timing(cfg_index, cfg_data);
			end
			if (in_valid && in_ready) begin
				line_q.push_back(advance_encoder(operation, header_word, command_code,
					invert_pass));
			end
			if (out_valid && out_ready) begin
				got = {line_level, busy_res, finished};
				if (line_q.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %b", $time, got);
					errs++;
				end else begin
					want = line_q.pop_front();
					check_bit("line_level", want.line_level, got.line_level);
					check_bit("busy_res", want.busy_res, got.busy_res);
					check_bit("finished", want.finished, got.finished);
				end
			end
			failures    <= errs;
			outstanding <= line_q.size();
		end
	end

endmodule

/* tb/sv/tb_rf_remote_pulse_width_transmitter_top.sv */
// ----------------------------------------------------------------------------
// tb_rf_remote_pulse_width_transmitter_top
// Drives tick and start items and timing register writes into the pulse
// width transmitter with random idle cycles on both sides; a line checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_rf_remote_pulse_width_transmitter_top;
	import rfpwt_pkg::*;

	localparam int unsigned FRAME_BITS    = 40;
	localparam int unsigned HOLD_AFTER    = 4;
	localparam int unsigned STALL_LIMIT   = 2000;
	localparam int unsigned PRESSURE_AT   = 500;
	localparam int unsigned PRESSURE_HOLD = 300;
	localparam int unsigned PHASES        = 4;
	localparam int unsigned PHASE_ITEMS   = 150;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(REG_REPEAT) + 1'b1;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic                 operation;
	logic [HDR_W-1:0]     header_word;
	logic [CMD_W-1:0]     command_code;
	logic                 invert_pass;
	logic                 out_valid;
	logic                 out_ready;
	logic                 line_level;
	logic                 busy_res;
	logic                 finished;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [TIME_W-1:0]    cfg_data;

	int unsigned failures;
	int unsigned outstanding;
	int unsigned idle_cycles = 0;
	bit          no_idle;

	rf_remote_pulse_width_transmitter_top #(
		.FRAME_BITS(FRAME_BITS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operation(operation),
		.header_word(header_word),
		.command_code(command_code),
		.invert_pass(invert_pass),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.line_level(line_level),
		.busy_res(busy_res),
		.finished(finished),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	rfpwt_line_checker #(
		.FRAME_BITS(FRAME_BITS)
	) i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operation(operation),
		.header_word(header_word),
		.command_code(command_code),
		.invert_pass(invert_pass),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.line_level(line_level),
		.busy_res(busy_res),
		.finished(finished),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.failures(failures),
		.outstanding(outstanding)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// watchdog: end the run when no channel has moved for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
				|| (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// result side: random stalls, one long hold-off to back up the input
	initial begin
		int unsigned stall;
		int unsigned taken;
		out_ready = 1'b0;
		taken     = 0;
		wait (arst_n);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 8);
			if (taken == PRESSURE_AT) begin
				stall = PRESSURE_HOLD;
			end
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			taken++;
		end
	end

	task automatic send_item(input logic op, input logic [HDR_W-1:0] hdr,
			input logic [CMD_W-1:0] cmd, input logic inv);
		int unsigned gap;
		gap = no_idle ? 0 : $urandom_range(0, 8);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		operation    <= op;
		header_word  <= hdr;
		command_code <= cmd;
		invert_pass  <= inv;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic send_tick();
		send_item(OP_TICK, $urandom(), CMD_W'($urandom()), 1'($urandom()));
	endtask

	task automatic send_start(input logic inv);
		send_item(OP_START, $urandom(), CMD_W'($urandom()), inv);
	endtask

	task automatic run_ticks(input int unsigned n);
		bit keep;
		keep    = no_idle;
		no_idle = 1'b1;
		repeat (n) send_tick();
		no_idle = keep;
	endtask

	// mostly ticks with an occasional start; starts while busy are dropped
	task automatic run_random(input int unsigned n);
		repeat (n) begin
			if ($urandom_range(0, 29) == 0) begin
				send_start(1'($urandom()));
			end else begin
				send_tick();
			end
		end
	endtask

	// wait for every pending result, then let the pipeline settle
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (HOLD_AFTER) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TIME_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_timing(input cfg_t c);
		write_reg(REG_SHORT, c.short_time);
		write_reg(REG_LONG, c.long_time);
		write_reg(REG_SYNC_HI, c.sync_high_time);
		write_reg(REG_SYNC_LO, c.sync_low_time);
		write_reg(REG_GAP, c.gap_time);
		// upper data bits are ignored for the repeat count
		write_reg(REG_REPEAT, {8'($urandom()), c.repeat_count});
	endtask

	function automatic cfg_t make_timing(input logic [TIME_W-1:0] s, input logic [TIME_W-1:0] l,
			input logic [TIME_W-1:0] sh, input logic [TIME_W-1:0] sl,
			input logic [TIME_W-1:0] g, input logic [COUNT_W-1:0] r);
		cfg_t c;
		c.short_time     = s;
		c.long_time      = l;
		c.sync_high_time = sh;
		c.sync_low_time  = sl;
		c.gap_time       = g;
		c.repeat_count   = r;
		return c;
	endfunction

	// short segments and few repeats to keep transmissions short
	function automatic cfg_t quick_timing();
		return make_timing(TIME_W'($urandom_range(0, 2)), TIME_W'($urandom_range(0, 3)),
			TIME_W'($urandom_range(0, 3)), TIME_W'($urandom_range(0, 3)),
			TIME_W'($urandom_range(0, 3)), COUNT_W'($urandom_range(1, 2)));
	endfunction

	initial begin
		int unsigned ph_i;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		operation    = OP_TICK;
		header_word  = '0;
		command_code = '0;
		invert_pass  = 1'b0;
		cfg_valid    = 1'b0;
		cfg_index    = REG_SHORT;
		cfg_data     = '0;
		no_idle      = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ticks while idle
		send_item(OP_TICK, '0, '0, 1'b0);
		send_item(OP_TICK, '1, '1, 1'b1);
		drain();

		// zero durations count as one tick; a full-ones start, a start while busy
		load_timing(make_timing(16'd0, 16'd1, 16'd0, 16'd2, 16'd0, 8'd2));
		write_reg(REG_SPARE + CFG_IDX_W'($urandom_range(0, 1)), TIME_W'($urandom()));
		send_item(OP_START, '1, '1, 1'b1);
		send_item(OP_START, '0, '0, 1'b0);
		run_ticks(400);
		send_item(OP_START, '0, '0, 1'b0);
		run_ticks(200);
		send_item(OP_START, 32'h8000_0001, 8'h5a, 1'b1);
		run_ticks(400);
		drain();

		// zero repeat count: a start is dropped
		write_reg(REG_REPEAT, '0);
		send_start(1'b1);
		send_tick();
		drain();

		// zero repeat count at the end of the first pass skips the second one
		write_reg(REG_REPEAT, TIME_W'(1));
		send_start(1'b1);
		run_ticks(10);
		drain();
		write_reg(REG_REPEAT, '0);
		run_ticks(100);
		drain();

		// distinct short and long parts on a random frame
		load_timing(make_timing(16'd3, 16'd5, 16'd6, 16'd4, 16'd8, 8'd1));
		send_start(1'b0);
		run_ticks(350);
		drain();

		for (ph_i = 0; ph_i < PHASES; ph_i++) begin
			load_timing(quick_timing());
			no_idle = (ph_i % 4 == 3);
			run_random(PHASE_ITEMS);
			drain();
		end
		no_idle = 1'b0;

		if (failures == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

/* rf_remote_pulse_width_transmitter_top.f */
sv/rfpwt_pkg.sv
sv/rfpwt_cfg.sv
sv/rfpwt_seq.sv
sv/rf_remote_pulse_width_transmitter_top.sv
tb/sv/rfpwt_line_checker.sv
tb/sv/tb_rf_remote_pulse_width_transmitter_top.sv
